@@ sv/ntp_reply_check_and_offset_defines.svh @@
// ----------------------------------------------------------------------------
// NTP reply check - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NTP_REPLY_CHECK_AND_OFFSET_DEFINES_SVH
`define NTP_REPLY_CHECK_AND_OFFSET_DEFINES_SVH

// same-cycle implication
`define NRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/nrc_pkg.sv @@
// ----------------------------------------------------------------------------
// NTP reply check - package
// Widths, register indexes, reject codes and check flags.
// ----------------------------------------------------------------------------
package nrc_pkg;

    localparam int IN_DATA_W  = 416;
    localparam int OUT_DATA_W = 272;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISPERSION  = 2'd2;

    localparam logic        RST_CHECK_ENABLE    = 1'b1;
    localparam logic [31:0] RST_PRECISION_FLOOR = 32'd4295;
    localparam logic [31:0] RST_MIN_DISPERSION  = 32'd4295;

    localparam logic [3:0] REASON_OK        = 4'd0;
    localparam logic [3:0] REASON_UNSYNCED  = 4'd1;
    localparam logic [3:0] REASON_VERSION   = 4'd2;
    localparam logic [3:0] REASON_MODE      = 4'd3;
    localparam logic [3:0] REASON_ORIGIN    = 4'd4;
    localparam logic [3:0] REASON_XMT_ZERO  = 4'd5;
    localparam logic [3:0] REASON_DELAY     = 4'd6;
    localparam logic [3:0] REASON_DISP      = 4'd7;
    localparam logic [3:0] REASON_STRATUM0  = 4'd8;

    localparam logic [1:0]  LEAP_UNSYNCED = 2'd3;
    localparam logic [2:0]  MIN_VERSION   = 3'd3;
    localparam logic [2:0]  MODE_SERVER   = 3'd4;
    localparam logic signed [31:0] ONE_SEC_16 = 32'sd65536;

    typedef struct packed {
        logic leap_bad;
        logic ver_bad;
        logic mode_bad;
        logic orig_bad;
        logic xmt_zero;
        logic delay_bad;
        logic disp_bad;
        logic stratum_zero;
    } check_flags_t;

    // 16.16 signed widened to 32.32
    function automatic logic [63:0] widen_16_16(input logic [31:0] v);
        return {{16{v[31]}}, v, 16'h0000};
    endfunction

endpackage

@@ sv/ntp_reply_check_and_offset.sv @@
// ----------------------------------------------------------------------------
// NTP reply check and clock offset
// Validates one server reply per word and computes offset, round trip and
// root delay / dispersion sums in signed 32.32.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one reply per word; m_* returns one result word per reply.
//   cfg_* writes check_enable (0), precision_floor (1), min_dispersion (2);
//   other indexes are ignored. cfg_ready is always high; write only while
//   the pipeline is empty.
//   Three register stages: differences and check flags, then round trip,
//   offset numerator and reject code, then floor, halving and sums, the
//   last one being the output register that drives m_tvalid. Throughput is
//   one reply per cycle while m_tready is high, set by the stage-to-stage
//   handshake with no shared units.
//   When m_tready is low, the stages fill up behind the output register and
//   s_tready falls once all three hold a word; nothing is lost or repeated.
//   Reset empties the pipeline and restores check_enable = 1 and both
//   fractions to 4295.
// ----------------------------------------------------------------------------
`include "ntp_reply_check_and_offset_defines.svh"

module ntp_reply_check_and_offset (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // header_word, peer_root_delay, peer_root_disp, originate_time,
    // receive_time, transmit_time, arrival_time, request_sent_time
    input  logic [nrc_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // accepted, reject_reason, stratum_out, clock_offset, round_trip,
    // root_delay_sum, root_disp_sum, zero padding
    output logic [nrc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import nrc_pkg::*;

    // configuration
    logic        check_enable_reg;
    logic [31:0] precision_floor_reg;
    logic [31:0] min_dispersion_reg;

    // input fields
    logic [31:0]        hdr;
    logic signed [31:0] dly_in;
    logic signed [31:0] dsp_in;
    logic [63:0]        t1, t2, t3, t4, sent;

    // stage 1
    logic         v1_reg;
    check_flags_t flags1_reg, flags1_next;
    logic [7:0]   stratum1_reg;
    logic [63:0]  d21_reg, d43_reg, d41_reg, d32_reg;
    logic [63:0]  dly1_reg, psum1_reg;

    // stage 2
    logic        v2_reg;
    logic [3:0]  reason2_reg, reason2_next;
    logic [7:0]  stratum2_reg;
    logic [63:0] rt2_reg, num2_reg, dly2_reg, psum2_reg;

    // stage 3 / output
    logic        v3_reg;
    logic [3:0]  reason3_reg;
    logic [7:0]  stratum3_reg;
    logic [63:0] off3_reg, rt3_reg, dsum3_reg, psum3_reg;
    logic [63:0] floored;

    logic en1, en2, en3;

    assign hdr    = s_tdata[31:0];
    assign dly_in = s_tdata[63:32];
    assign dsp_in = s_tdata[95:64];
    assign t1     = s_tdata[159:96];
    assign t2     = s_tdata[223:160];
    assign t3     = s_tdata[287:224];
    assign t4     = s_tdata[351:288];
    assign sent   = s_tdata[415:352];

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg    <= RST_CHECK_ENABLE;
            precision_floor_reg <= RST_PRECISION_FLOOR;
            min_dispersion_reg  <= RST_MIN_DISPERSION;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CHECK_ENABLE:    check_enable_reg    <= cfg_data[0];
                CFG_PRECISION_FLOOR: precision_floor_reg <= cfg_data;
                CFG_MIN_DISPERSION:  min_dispersion_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        flags1_next.leap_bad     = (hdr[31:30] == LEAP_UNSYNCED);
        flags1_next.ver_bad      = (hdr[29:27] < MIN_VERSION);
        flags1_next.mode_bad     = (hdr[26:24] != MODE_SERVER);
        flags1_next.orig_bad     = (t1 != sent);
        flags1_next.xmt_zero     = (t3 == 64'd0);
        flags1_next.delay_bad    = (dly_in > ONE_SEC_16) || (dly_in < -ONE_SEC_16);
        flags1_next.disp_bad     = (dsp_in > ONE_SEC_16) || (dsp_in < -ONE_SEC_16);
        flags1_next.stratum_zero = (hdr[23:16] == 8'd0);
    end

    // first failing check wins
    always_comb
    begin
        reason2_next = REASON_OK;
        if (check_enable_reg)
        begin
            if (flags1_reg.leap_bad)          reason2_next = REASON_UNSYNCED;
            else if (flags1_reg.ver_bad)      reason2_next = REASON_VERSION;
            else if (flags1_reg.mode_bad)     reason2_next = REASON_MODE;
            else if (flags1_reg.orig_bad)     reason2_next = REASON_ORIGIN;
            else if (flags1_reg.xmt_zero)     reason2_next = REASON_XMT_ZERO;
            else if (flags1_reg.delay_bad)    reason2_next = REASON_DELAY;
            else if (flags1_reg.disp_bad)     reason2_next = REASON_DISP;
            else if (flags1_reg.stratum_zero) reason2_next = REASON_STRATUM0;
        end
    end

    assign floored = ($signed(rt2_reg) < $signed({32'h0, precision_floor_reg}))
                   ? {32'h0, precision_floor_reg} : rt2_reg;

    // datapath
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            flags1_reg   <= flags1_next;
            stratum1_reg <= hdr[23:16];
            d21_reg      <= t2 - t1;
            d43_reg      <= t4 - t3;
            d41_reg      <= t4 - t1;
            d32_reg      <= t3 - t2;
            dly1_reg     <= widen_16_16(dly_in);
            psum1_reg    <= widen_16_16(dsp_in) + {32'h0, precision_floor_reg};
        end
        if (en2)
        begin
            reason2_reg  <= reason2_next;
            stratum2_reg <= stratum1_reg;
            rt2_reg      <= d41_reg - d32_reg;
            num2_reg     <= d21_reg - d43_reg;
            dly2_reg     <= dly1_reg;
            psum2_reg    <= psum1_reg + {32'h0, min_dispersion_reg};
        end
        if (en3)
        begin
            reason3_reg  <= reason2_reg;
            stratum3_reg <= stratum2_reg;
            off3_reg     <= {num2_reg[63], num2_reg[63:1]};
            rt3_reg      <= rt2_reg;
            dsum3_reg    <= dly2_reg + floored;
            psum3_reg    <= psum2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {3'b000, psum3_reg, dsum3_reg, rt3_reg, off3_reg,
                       stratum3_reg, reason3_reg, (reason3_reg == REASON_OK)};

    `NRC_ASSERT_SAME(a_full_blocks_input, v1_reg && v2_reg && v3_reg && !m_tready,
        !s_tready, "input taken while pipeline full and stalled")
    `NRC_ASSERT_SAME(a_reason_range, m_tvalid, reason3_reg <= REASON_STRATUM0,
        "reject code out of range")
    `NRC_ASSERT_NEXT(a_stage2_moves, v2_reg && en3, v3_reg,
        "word lost between stage 2 and output")

endmodule
